// ===== src/pemj_pkg.sv =====
package pemj_pkg;

	localparam int FracBits = 16;
	localparam int TickBits = 32;
	localparam int WeightBits = FracBits + 1;
	localparam int ProdBits = 2 * WeightBits;

	localparam logic [WeightBits-1:0] OneFx = WeightBits'(1) << FracBits;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_POSTURE = 3'd1,
		MODE_GESTURE = 3'd2,
		MODE_SETTLE  = 3'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_PHASES  = 3'd1,
		REG_START   = 3'd2,
		REG_ONSET   = 3'd3,
		REG_PEAK    = 3'd4,
		REG_RELEASE = 3'd5,
		REG_END     = 3'd6,
		REG_RAMP    = 3'd7
	} reg_idx_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INACTIVE = 2'd1;
	localparam logic [1:0] ST_INVALID  = 2'd2;

	localparam logic [1:0] SG_STEADY = 2'd0;
	localparam logic [1:0] SG_ENTER  = 2'd1;
	localparam logic [1:0] SG_HOLD   = 2'd2;
	localparam logic [1:0] SG_EXIT   = 2'd3;

	localparam logic [6:0] MASK_ONSET   = 7'h02;
	localparam logic [6:0] MASK_GESTURE = 7'h1F;
	localparam logic [6:0] MASK_SETTLE  = 7'h60;

	typedef struct packed {
		logic [1:0]          status;
		logic [1:0]          stage;
		logic                ramp;
		logic                invert;
		logic                full;
		logic [TickBits-1:0] num;
		logic [TickBits-1:0] den;
	} job_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [1:0]            stage;
		logic                  ramp;
		logic                  invert;
		logic [TickBits:0]     rem;
		logic [TickBits-1:0]   den;
		logic [FracBits-1:0]   q;
	} div_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [1:0]            stage;
		logic                  ramp;
		logic                  invert;
		logic [WeightBits-1:0] p;
		logic [WeightBits-1:0] p2;
		logic [WeightBits-1:0] p3;
		logic [WeightBits+4:0] inner;
	} poly_t;

endpackage

// ===== src/pemj_front.sv =====
module pemj_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic [pemj_pkg::TickBits-1:0]  now,
	output pemj_pkg::job_t                 job
);

	logic [2:0]                    mode_q;
	logic [6:0]                    phases_q;
	logic [pemj_pkg::TickBits-1:0] start_q, onset_q, peak_q, release_q, end_q;
	logic [15:0]                   ramp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= '0;
			phases_q  <= '0;
			start_q   <= '0;
			onset_q   <= '0;
			peak_q    <= '0;
			release_q <= '0;
			end_q     <= '0;
			ramp_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pemj_pkg::REG_MODE:    mode_q    <= cfg_data[2:0];
				pemj_pkg::REG_PHASES:  phases_q  <= cfg_data[6:0];
				pemj_pkg::REG_START:   start_q   <= cfg_data[pemj_pkg::TickBits-1:0];
				pemj_pkg::REG_ONSET:   onset_q   <= cfg_data[pemj_pkg::TickBits-1:0];
				pemj_pkg::REG_PEAK:    peak_q    <= cfg_data[pemj_pkg::TickBits-1:0];
				pemj_pkg::REG_RELEASE: release_q <= cfg_data[pemj_pkg::TickBits-1:0];
				pemj_pkg::REG_END:     end_q     <= cfg_data[pemj_pkg::TickBits-1:0];
				pemj_pkg::REG_RAMP:    ramp_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [pemj_pkg::TickBits-1:0] el;

	always_comb begin
		job = '0;
		job.status = pemj_pkg::ST_OK;
		job.stage = pemj_pkg::SG_STEADY;
		job.full = 1'b1;
		el = now - start_q;
		case (mode_q)
			pemj_pkg::MODE_IDLE: begin
				if (phases_q != 7'd0) job.status = pemj_pkg::ST_INVALID;
			end
			pemj_pkg::MODE_POSTURE: begin
				if (phases_q != pemj_pkg::MASK_ONSET || ramp_q == 16'd0)
					job.status = pemj_pkg::ST_INVALID;
				else if (now < start_q)
					job.status = pemj_pkg::ST_INACTIVE;
				else if (el < pemj_pkg::TickBits'(ramp_q)) begin
					job.stage = pemj_pkg::SG_ENTER;
					job.ramp = 1'b1;
					job.num = el;
					job.den = pemj_pkg::TickBits'(ramp_q);
				end else
					job.stage = pemj_pkg::SG_HOLD;
			end
			pemj_pkg::MODE_GESTURE: begin
				if (phases_q != pemj_pkg::MASK_GESTURE || start_q >= onset_q ||
						onset_q >= peak_q || peak_q >= release_q || release_q >= end_q)
					job.status = pemj_pkg::ST_INVALID;
				else if (now < start_q || now > end_q)
					job.status = pemj_pkg::ST_INACTIVE;
				else if (now < onset_q) begin
					job.stage = pemj_pkg::SG_ENTER;
					job.ramp = 1'b1;
					job.num = el;
					job.den = onset_q - start_q;
				end else if (now <= release_q)
					job.stage = pemj_pkg::SG_HOLD;
				else begin
					job.stage = pemj_pkg::SG_EXIT;
					job.ramp = 1'b1;
					job.invert = 1'b1;
					job.num = now - release_q;
					job.den = end_q - release_q;
				end
			end
			pemj_pkg::MODE_SETTLE: begin
				if (phases_q != pemj_pkg::MASK_SETTLE || start_q >= end_q)
					job.status = pemj_pkg::ST_INVALID;
				else if (now < start_q || now > end_q)
					job.status = pemj_pkg::ST_INACTIVE;
				else if (now < end_q) begin
					job.stage = pemj_pkg::SG_ENTER;
					job.ramp = 1'b1;
					job.num = el;
					job.den = end_q - start_q;
				end else
					job.stage = pemj_pkg::SG_HOLD;
			end
			default: job.status = pemj_pkg::ST_INVALID;
		endcase
		if (job.ramp && job.num >= job.den) job.full = 1'b1;
		else if (job.ramp) job.full = 1'b0;
	end

endmodule

// ===== src/pemj_fifo.sv =====
module pemj_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pemj_pkg::job_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           nonempty,
	output pemj_pkg::job_t rdata
);

	pemj_pkg::job_t mem_q [2];
	logic [1:0] wp_q, rp_q;

	assign full = (wp_q[0] == rp_q[0]) && (wp_q[1] != rp_q[1]);
	assign nonempty = wp_q != rp_q;
	assign rdata = mem_q[rp_q[0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q[0]] <= wdata;
	end

endmodule

// ===== src/pemj_back.sv =====
module pemj_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  pemj_pkg::job_t                   in_job,
	output logic                             in_take,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       out_status,
	output logic [1:0]                       out_stage,
	output logic [pemj_pkg::WeightBits-1:0]  out_weight
);

	localparam int Nd = pemj_pkg::FracBits;
	localparam int Ns = Nd + 4;
	localparam int TB = pemj_pkg::TickBits;
	localparam int WB = pemj_pkg::WeightBits;
	localparam int PB = pemj_pkg::ProdBits;

	logic [Ns-1:0] v_q;
	logic          adv;

	assign adv = !(v_q[Ns-1] && out_stall);
	assign in_take = in_valid && adv;
	assign out_valid = v_q[Ns-1];

	pemj_pkg::div_t d_s [Nd+1];
	pemj_pkg::poly_t p_s1, p_s2, p_s3;
	logic [1:0] st_s4, sg_s4;
	logic [WB-1:0] w_s4;
	logic [PB+5:0] prod;
	logic [WB+4:0] wr;
	logic [WB-1:0] wc;
	logic [1:0]    st_c;
	logic [1:0]    sg_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[Ns-2:0], in_take};
	end

	always_comb begin
		d_s[0] = '0;
		d_s[0].status = in_job.status;
		d_s[0].stage = in_job.stage;
		d_s[0].ramp = in_job.ramp && !in_job.full;
		d_s[0].invert = in_job.invert;
		d_s[0].rem = {1'b0, in_job.num};
		d_s[0].den = in_job.den;
		d_s[0].q = '0;
	end

	for (genvar g = 0; g < Nd; g++) begin : g_div
		pemj_pkg::div_t r_q;
		pemj_pkg::div_t nx;
		logic [TB:0] gap;
		always_comb begin
			nx = (g == 0) ? d_s[0] : d_s[g];
			gap = {1'b0, nx.den} - nx.rem;
			nx.q = {nx.q[Nd-2:0], 1'b0};
			if (nx.rem >= gap) begin
				nx.rem = nx.rem - gap;
				nx.q[0] = 1'b1;
			end else
				nx.rem = {nx.rem[TB-1:0], 1'b0};
		end
		always_ff @(posedge clk) if (adv) r_q <= nx;
		assign d_s[g+1] = r_q;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1.status <= d_s[Nd].status;
			p_s1.stage <= d_s[Nd].stage;
			p_s1.ramp <= d_s[Nd].ramp;
			p_s1.invert <= d_s[Nd].invert;
			p_s1.p <= d_s[Nd].ramp ? {1'b0, d_s[Nd].q} : pemj_pkg::OneFx;
			p_s1.p2 <= '0;
			p_s1.p3 <= '0;
			p_s1.inner <= '0;

			p_s2.status <= p_s1.status;
			p_s2.stage <= p_s1.stage;
			p_s2.ramp <= p_s1.ramp;
			p_s2.invert <= p_s1.invert;
			p_s2.p <= p_s1.p;
			p_s2.p2 <= WB'((PB'(p_s1.p) * PB'(p_s1.p)) >> Nd);
			p_s2.p3 <= '0;
			p_s2.inner <= '0;

			p_s3.status <= p_s2.status;
			p_s3.stage <= p_s2.stage;
			p_s3.ramp <= p_s2.ramp;
			p_s3.invert <= p_s2.invert;
			p_s3.p <= p_s2.p;
			p_s3.p2 <= p_s2.p2;
			p_s3.p3 <= WB'((PB'(p_s2.p2) * PB'(p_s2.p)) >> Nd);
			p_s3.inner <= (WB+5)'(10) * (WB+5)'(pemj_pkg::OneFx)
				+ (WB+5)'(6) * (WB+5)'(p_s2.p2) - (WB+5)'(15) * (WB+5)'(p_s2.p);

			st_s4 <= st_c;
			sg_s4 <= sg_c;
			w_s4 <= wc;
		end
	end

	always_comb begin
		prod = (PB+6)'(p_s3.p3) * (PB+6)'(p_s3.inner);
		wr = (WB+5)'(prod >> Nd);
		wc = (wr > (WB+5)'(pemj_pkg::OneFx)) ? pemj_pkg::OneFx : wr[WB-1:0];
		if (!p_s3.ramp) wc = pemj_pkg::OneFx;
		if (p_s3.invert) wc = pemj_pkg::OneFx - wc;
		st_c = p_s3.status;
		sg_c = p_s3.stage;
		if (p_s3.status != pemj_pkg::ST_OK) begin
			sg_c = pemj_pkg::SG_STEADY;
			wc = '0;
		end
	end

	assign out_status = st_s4;
	assign out_stage = sg_s4;
	assign out_weight = w_s4;

endmodule

// ===== src/phase_envelope_min_jerk.sv =====
// Pipeline: 1 front register, 1 queue entry, 16 divide steps and 4 polynomial
// stages lie between an accepted item and its result.
// Throughput: one item per cycle unless out_stall or a full queue stalls; the
// pipelined bit-per-stage divider and registered multiplier chain do likewise.
// Reset: asynchronous, active low; configuration registers and valid flags clear to 0,
// so the pipeline empties; data registers are not reset.
module phase_envelope_min_jerk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [1:0]  stage,
	output logic [16:0] weight,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	pemj_pkg::job_t job, job_q, qd;
	logic job_v_q, q_full, q_ne, take, push;

	pemj_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .now(now_tick[pemj_pkg::TickBits-1:0]), .job(job)
	);

	assign push = job_v_q && !q_full;
	assign in_stall = job_v_q && q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) job_v_q <= 1'b0;
		else if (!in_stall) job_v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall) job_q <= job;
	end

	pemj_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(job_q), .full(q_full),
		.pop(take), .nonempty(q_ne), .rdata(qd)
	);

	pemj_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_ne), .in_job(qd), .in_take(take),
		.out_valid(out_valid), .out_stall(out_stall), .out_status(status),
		.out_stage(stage), .out_weight(weight)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

	localparam logic [16:0] ONE_W = 17'h10000;
	localparam int PIPE_CYCLES = 22;

	class envelope_scoreboard;
		logic [2:0]  mode;
		logic [6:0]  phases;
		logic [31:0] t_start, t_onset, t_peak, t_release, t_end;
		logic [15:0] ramp_len;
		logic [1:0]  exp_status[$];
		logic [1:0]  exp_stage[$];
		logic [16:0] exp_weight[$];
		int          errors;

		function void clear_regs();
			mode = 0; phases = 0; t_start = 0; t_onset = 0; t_peak = 0;
			t_release = 0; t_end = 0; ramp_len = 0; errors = 0;
		endfunction

		function void write_reg(pemj_pkg::reg_idx_t idx, logic [31:0] d);
			case (idx)
				pemj_pkg::REG_MODE: mode = d[2:0];
				pemj_pkg::REG_PHASES: phases = d[6:0];
				pemj_pkg::REG_START: t_start = d;
				pemj_pkg::REG_ONSET: t_onset = d;
				pemj_pkg::REG_PEAK: t_peak = d;
				pemj_pkg::REG_RELEASE: t_release = d;
				pemj_pkg::REG_END: t_end = d;
				pemj_pkg::REG_RAMP: ramp_len = d[15:0];
				default: ;
			endcase
		endfunction

		function logic [16:0] progress(logic [63:0] num, logic [63:0] den);
			logic [63:0] rem, gap;
			logic [16:0] q;
			rem = num;
			q = 0;
			if (den == 0 || num >= den)
				return ONE_W;
			for (int i = 0; i < 16; i++) begin
				gap = den - rem;
				q = q << 1;
				if (rem >= gap) begin
					rem = rem - gap;
					q[0] = 1'b1;
				end else
					rem = rem << 1;
			end
			return q;
		endfunction

		function logic [16:0] min_jerk(logic [16:0] p_in);
			logic [63:0] p, p2, p3, inr, w;
			p = p_in;
			if (p > 64'h10000)
				p = 64'h10000;
			p2 = (p * p) >> 16;
			p3 = (p2 * p) >> 16;
			inr = 10 * 64'h10000 + 6 * p2 - 15 * p;
			w = (p3 * inr) >> 16;
			return (w > 64'h10000) ? ONE_W : w[16:0];
		endfunction

		function void note_tick(logic [31:0] now);
			logic [1:0]  st, sg;
			logic [16:0] w;
			st = pemj_pkg::ST_OK; sg = pemj_pkg::SG_STEADY; w = ONE_W;
			case (mode)
				pemj_pkg::MODE_IDLE: if (phases != 0) st = pemj_pkg::ST_INVALID;
				pemj_pkg::MODE_POSTURE: begin
					if (phases != pemj_pkg::MASK_ONSET || ramp_len == 0)
						st = pemj_pkg::ST_INVALID;
					else if (now < t_start)
						st = pemj_pkg::ST_INACTIVE;
					else if (now - t_start < ramp_len) begin
						sg = pemj_pkg::SG_ENTER;
						w = min_jerk(progress(now - t_start, ramp_len));
					end else
						sg = pemj_pkg::SG_HOLD;
				end
				pemj_pkg::MODE_GESTURE: begin
					if (phases != pemj_pkg::MASK_GESTURE || t_start >= t_onset
							|| t_onset >= t_peak || t_peak >= t_release
							|| t_release >= t_end)
						st = pemj_pkg::ST_INVALID;
					else if (now < t_start || now > t_end)
						st = pemj_pkg::ST_INACTIVE;
					else if (now < t_onset) begin
						sg = pemj_pkg::SG_ENTER;
						w = min_jerk(progress(now - t_start, t_onset - t_start));
					end else if (now <= t_release)
						sg = pemj_pkg::SG_HOLD;
					else begin
						sg = pemj_pkg::SG_EXIT;
						w = ONE_W - min_jerk(progress(now - t_release, t_end - t_release));
					end
				end
				pemj_pkg::MODE_SETTLE: begin
					if (phases != pemj_pkg::MASK_SETTLE || t_start >= t_end)
						st = pemj_pkg::ST_INVALID;
					else if (now < t_start || now > t_end)
						st = pemj_pkg::ST_INACTIVE;
					else if (now < t_end) begin
						sg = pemj_pkg::SG_ENTER;
						w = min_jerk(progress(now - t_start, t_end - t_start));
					end else
						sg = pemj_pkg::SG_HOLD;
				end
				default: st = pemj_pkg::ST_INVALID;
			endcase
			if (st != pemj_pkg::ST_OK) begin
				sg = pemj_pkg::SG_STEADY;
				w = 0;
			end
			exp_status.push_back(st);
			exp_stage.push_back(sg);
			exp_weight.push_back(w);
		endfunction

		function void check_result(logic [1:0] st, logic [1:0] sg, logic [16:0] w);
			logic [1:0]  es, eg;
			logic [16:0] ew;
			if (exp_status.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			es = exp_status.pop_front();
			eg = exp_stage.pop_front();
			ew = exp_weight.pop_front();
			if (st !== es) begin
				$error("status expected %0d actual %0d", es, st);
				errors++;
			end
			if (sg !== eg) begin
				$error("stage expected %0d actual %0d", eg, sg);
				errors++;
			end
			if (w !== ew) begin
				$error("weight expected %0d actual %0d", ew, w);
				errors++;
			end
		endfunction

		function int pending();
			return exp_status.size();
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [31:0] now_tick = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  status, stage;
	logic [16:0] weight;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic        stimulus_done = 0;

	envelope_scoreboard sb = new();

	phase_envelope_min_jerk uut (.*);

	always #1 clk = ~clk;

	task automatic write_reg(pemj_pkg::reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic load_profile(logic [2:0] m, logic [6:0] ph, logic [31:0] s, logic [31:0] o,
			logic [31:0] p, logic [31:0] r, logic [31:0] e, logic [15:0] d);
		write_reg(pemj_pkg::REG_MODE, m);
		write_reg(pemj_pkg::REG_PHASES, ph);
		write_reg(pemj_pkg::REG_START, s);
		write_reg(pemj_pkg::REG_ONSET, o);
		write_reg(pemj_pkg::REG_PEAK, p);
		write_reg(pemj_pkg::REG_RELEASE, r);
		write_reg(pemj_pkg::REG_END, e);
		write_reg(pemj_pkg::REG_RAMP, d);
	endtask

	task automatic send_tick(logic [31:0] t, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		now_tick <= t;
		do @(posedge clk); while (in_stall);
		sb.note_tick(t);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [31:0] near(logic [31:0] a, logic [31:0] b);
		case ($urandom_range(0, 5))
			0: return a;
			1: return b;
			2: return a - 1;
			3: return b + 1;
			default: return a + $urandom_range(0, b - a);
		endcase
	endfunction

	always @(posedge clk)
		if (out_valid && !out_stall)
			sb.check_result(status, stage, weight);

	initial begin
		out_stall = 0;
		@(negedge clk);
		forever begin
			@(negedge clk);
			if (stimulus_done)
				out_stall <= 0;
			else if ($urandom_range(0, 3) == 0)
				out_stall <= ($urandom_range(0, 12) != 0);
			else
				out_stall <= 0;
		end
	end

	initial begin
		logic [31:0] s, o, p, r, e, lo, hi;
		logic [15:0] d;
		logic [2:0]  m;
		sb.clear_regs();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: idle, invalid sets, extremes
		send_tick(0);
		send_tick(32'hFFFF_FFFF);
		drain();
		load_profile(pemj_pkg::MODE_IDLE, 7'h7F, 0, 0, 0, 0, 0, 0);
		send_tick(5);
		drain();
		load_profile(pemj_pkg::MODE_POSTURE, pemj_pkg::MASK_ONSET, 32'd100, 0, 0, 0, 0,
				16'hFFFF);
		send_tick(99); send_tick(100); send_tick(101); send_tick(100 + 32'h7FFF);
		send_tick(100 + 65534); send_tick(100 + 65535); send_tick(32'hFFFF_FFFF);
		drain();
		write_reg(pemj_pkg::REG_RAMP, 0);
		send_tick(200);
		drain();
		load_profile(pemj_pkg::MODE_GESTURE, pemj_pkg::MASK_GESTURE, 10, 20, 30, 40,
				32'hFFFF_FFFF, 1);
		send_tick(9); send_tick(10); send_tick(15); send_tick(20); send_tick(40);
		send_tick(41); send_tick(32'hFFFF_FFFE); send_tick(32'hFFFF_FFFF);
		drain();
		write_reg(pemj_pkg::REG_PEAK, 40);
		send_tick(25);
		drain();
		load_profile(pemj_pkg::MODE_SETTLE, pemj_pkg::MASK_SETTLE, 0, 0, 0, 0,
				32'hFFFF_FFFF, 0);
		send_tick(0); send_tick(32'h8000_0000); send_tick(32'hFFFF_FFFF);
		drain();
		write_reg(pemj_pkg::REG_MODE, 3'd4);
		send_tick(1);
		drain();
		write_reg(pemj_pkg::REG_MODE, 3'd7);
		send_tick(1);
		drain();
		// random phases
		for (int ph = 0; ph < 28; ph++) begin
			m = $urandom_range(0, 9) < 8 ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
			s = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000);
			o = s + $urandom_range(1, 3000);
			p = o + $urandom_range(1, 50);
			r = p + $urandom_range(1, 3000);
			e = r + $urandom_range(1, 3000);
			if (ph % 7 == 3) begin s = 0; e = 32'hFFFF_FFFF; end
			d = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4000));
			if ($urandom_range(0, 9) == 0) p = o;
			case (m)
				pemj_pkg::MODE_POSTURE: load_profile(m, $urandom_range(0, 9) == 0 ?
						7'($urandom) : pemj_pkg::MASK_ONSET, s, $urandom, $urandom,
						$urandom, $urandom, d);
				pemj_pkg::MODE_GESTURE: load_profile(m, $urandom_range(0, 9) == 0 ?
						7'($urandom) : pemj_pkg::MASK_GESTURE, s, o, p, r, e, d);
				pemj_pkg::MODE_SETTLE: load_profile(m, $urandom_range(0, 9) == 0 ?
						7'($urandom) : pemj_pkg::MASK_SETTLE, s, $urandom, $urandom,
						$urandom, e, d);
				default: load_profile(m, $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'h0,
						$urandom, $urandom, $urandom, $urandom, $urandom, d);
			endcase
			lo = (s > 10) ? s - 10 : 0;
			hi = (m == pemj_pkg::MODE_POSTURE) ? s + d + 10 : e + 10;
			if (hi < lo) hi = 32'hFFFF_FFFF;
			for (int k = 0; k < 25; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_tick($urandom, ph % 4 == 0);
				else
					send_tick(near(lo, hi), ph % 4 == 0);
			end
			drain();
		end
		stimulus_done = 1;
		repeat (PIPE_CYCLES + 10) @(negedge clk);
		if (sb.pending() == 0 && sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
